// ===== hw/rtl/svi_pkg.sv =====
// Package for the servo sync step interpolator: widths, request and register codes,
// channel payload structs and divider handshake structs.
// No dependencies.
package svi_pkg;

    localparam int AXES           = 3;
    localparam int PULSE_BITS     = 12;
    localparam int OUT_PULSE_BITS = 12;
    localparam int CFG_PULSE_BITS = 12;
    localparam int ANGLE_BITS     = 8;
    localparam int INTERVAL_BITS  = 16;
    localparam int REQ_TYPE_BITS  = 2;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int LIMIT_SETS     = 3;

    localparam int ANGLE_OFFSET   = 45;
    localparam int MAP_SPAN_DEG   = 90;

    localparam int AX_W           = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int MAP_PROD_BITS  = ANGLE_BITS + CFG_PULSE_BITS + 4;
    localparam int PROD_MAG_BITS  = 20;
    localparam int DIVIDEND_BITS  = (PROD_MAG_BITS > PULSE_BITS) ? PROD_MAG_BITS : PULSE_BITS;
    localparam int DIVISOR_BITS   = (PULSE_BITS > 7) ? PULSE_BITS : 7;
    localparam int DIV_CNT_W      = $clog2(DIVIDEND_BITS);
    localparam int MAP_V_BITS     = DIVIDEND_BITS + 2;

    localparam logic [REQ_TYPE_BITS-1:0] REQ_SET  = 2'd0;
    localparam logic [REQ_TYPE_BITS-1:0] REQ_TICK = 2'd1;
    localparam logic [REQ_TYPE_BITS-1:0] REQ_SNAP = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_COXA_MIN  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COXA_MAX  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEMUR_MIN = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEMUR_MAX = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIBIA_MIN = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIBIA_MAX = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL  = 3'd6;

    localparam logic [CFG_PULSE_BITS-1:0] MIN_PULSE_RST = 12'd150;
    localparam logic [CFG_PULSE_BITS-1:0] MAX_PULSE_RST = 12'd600;
    localparam logic [INTERVAL_BITS-1:0]  INTERVAL_RST  = 16'd20;

    typedef struct packed {
        logic [REQ_TYPE_BITS-1:0] req_type;
        logic [ANGLE_BITS-1:0]    hip_angle;
        logic [ANGLE_BITS-1:0]    upper_angle;
        logic [ANGLE_BITS-1:0]    lower_angle;
    } t_req;

    typedef struct packed {
        logic [OUT_PULSE_BITS-1:0] hip_pulse;
        logic [OUT_PULSE_BITS-1:0] upper_pulse;
        logic [OUT_PULSE_BITS-1:0] lower_pulse;
        logic                      moved;
        logic                      arrived;
    } t_rsp;

    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [DIVISOR_BITS-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic [DIVIDEND_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hw/rtl/svi_req_if.sv =====
// Request channel: valid/ready handshake carrying one t_req transaction.
// Depends on svi_pkg.
interface svi_req_if;
    import svi_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/svi_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one t_rsp transaction.
// Depends on svi_pkg.
interface svi_rsp_if;
    import svi_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/svi_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on svi_pkg.
module svi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  svi_pkg::t_div_req  i_req,
    output svi_pkg::t_div_rsp  o_rsp
);
    import svi_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [DIVISOR_BITS-1:0]  r_dsr;

    logic [DIVISOR_BITS:0]    trial;
    logic                     fits;
    logic [DIVISOR_BITS:0]    trial_sub;

    assign trial     = {r_rem, r_quo[DIVIDEND_BITS-1]};
    assign fits      = (trial >= {1'b0, r_dsr});
    assign trial_sub = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_quo  <= '0;
            r_rem  <= '0;
            r_dsr  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= fits ? trial_sub[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
                r_quo <= {r_quo[DIVIDEND_BITS-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIVIDEND_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== hw/rtl/servo_sync_step_interpolator_core.sv =====
// Top level of the three-axis servo interpolator: request FSM, axis state, config registers.
// Depends on svi_pkg, svi_req_if, svi_rsp_if and svi_div.
//
//   channel   | direction | transaction
//   i_req     | in        | req_type, hip_angle, upper_angle, lower_angle
//   o_rsp     | out       | hip_pulse, upper_pulse, lower_pulse, moved, arrived
//   i_cfg_*   | in        | register write (index, data), no handshake
//
// Set and snap: per axis, load, 20-bit serial divide by 90, commit, then the response.
// Tick with a step: a minimum search over the axes, then a serial r/d divide per axis.
// One bit-serial divider is shared by the mapping and the step divides.
// Synchronous active-low reset; no clearing pass. A new request is taken while the
// previous response waits; the block stalls at completion until the output register frees.
module servo_sync_step_interpolator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    svi_req_if.sink                          i_req,
    svi_rsp_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [svi_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [svi_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata
);
    import svi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_START,
        S_MAP_DIV,
        S_DMIN,
        S_STEP_START,
        S_STEP_DIV,
        S_DONE
    } t_state;

    function automatic logic [1:0] lim_idx(input logic [AX_W-1:0] ax);
        logic [1:0] k;
        if (int'(ax) < 2) k = 2'(ax);
        else              k = 2'd2;
        return k;
    endfunction

    t_state                     r_state;
    logic [REQ_TYPE_BITS-1:0]   r_type;
    logic [ANGLE_BITS-1:0]      r_ang [LIMIT_SETS];
    logic [AX_W-1:0]            r_ax;
    logic [PULSE_BITS-1:0]      r_d;
    logic                       r_neg;
    logic                       r_moved;
    logic [PULSE_BITS-1:0]      r_cur [AXES];
    logic [PULSE_BITS-1:0]      r_tgt [AXES];
    logic [INTERVAL_BITS-1:0]   r_elapsed;
    logic [CFG_PULSE_BITS-1:0]  r_cfg_min [LIMIT_SETS];
    logic [CFG_PULSE_BITS-1:0]  r_cfg_max [LIMIT_SETS];
    logic [INTERVAL_BITS-1:0]   r_interval;
    logic                       r_rsp_valid;
    t_rsp                       r_rsp;

    t_div_req                   div_req;
    t_div_rsp                   div_rsp;

    logic [1:0]                     ax_k;
    logic [ANGLE_BITS-1:0]          map_angle;
    logic [CFG_PULSE_BITS-1:0]      map_lo;
    logic [CFG_PULSE_BITS-1:0]      map_hi;
    logic signed [ANGLE_BITS+1:0]   map_diff;
    logic signed [CFG_PULSE_BITS+1:0] map_span;
    logic signed [MAP_PROD_BITS-1:0] map_prod;
    logic [MAP_PROD_BITS-1:0]       map_mag;
    logic signed [MAP_V_BITS-1:0]   map_q;
    logic signed [MAP_V_BITS-1:0]   map_lo_s;
    logic signed [MAP_V_BITS-1:0]   map_hi_s;
    logic signed [MAP_V_BITS-1:0]   map_v;
    logic signed [MAP_V_BITS-1:0]   map_clamped;
    logic [PULSE_BITS-1:0]          map_pulse;

    logic [PULSE_BITS-1:0]          sel_cur;
    logic [PULSE_BITS-1:0]          sel_tgt;
    logic [PULSE_BITS-1:0]          sel_dist;
    logic [PULSE_BITS-1:0]          dmin_next;
    logic [PULSE_BITS-1:0]          step_inc;
    logic [PULSE_BITS-1:0]          step_next;

    logic [INTERVAL_BITS-1:0]       elapsed_inc;
    logic                           all_arrived;
    logic [OUT_PULSE_BITS-1:0]      rep_pulse [3];
    logic                           rsp_free;
    logic                           last_ax;

    // angle to pulse mapping for the current axis
    assign ax_k      = lim_idx(r_ax);
    assign map_angle = r_ang[ax_k];
    assign map_lo    = r_cfg_min[ax_k];
    assign map_hi    = r_cfg_max[ax_k];
    assign map_diff  = $signed({2'b00, map_angle}) - $signed((ANGLE_BITS+2)'(ANGLE_OFFSET));
    assign map_span  = $signed({2'b00, map_hi}) - $signed({2'b00, map_lo});
    assign map_prod  = map_diff * map_span;
    assign map_mag   = map_prod[MAP_PROD_BITS-1] ? MAP_PROD_BITS'(-map_prod)
                                                 : MAP_PROD_BITS'(map_prod);

    assign map_q    = $signed({2'b00, div_rsp.quotient});
    assign map_lo_s = $signed(MAP_V_BITS'(map_lo));
    assign map_hi_s = $signed(MAP_V_BITS'(map_hi));
    assign map_v    = r_neg ? (map_lo_s - map_q) : (map_lo_s + map_q);

    always_comb begin
        if (map_v < map_lo_s)      map_clamped = map_lo_s;
        else if (map_v > map_hi_s) map_clamped = map_hi_s;
        else                       map_clamped = map_v;
    end
    assign map_pulse = map_clamped[PULSE_BITS-1:0];

    // movement step helpers
    assign sel_cur   = r_cur[r_ax];
    assign sel_tgt   = r_tgt[r_ax];
    assign sel_dist  = (sel_cur > sel_tgt) ? (sel_cur - sel_tgt) : (sel_tgt - sel_cur);
    assign dmin_next = ((sel_dist != '0) && ((r_d == '0) || (sel_dist < r_d))) ? sel_dist : r_d;
    assign step_inc  = div_rsp.quotient[PULSE_BITS-1:0];
    assign step_next = (sel_cur > sel_tgt) ? (sel_cur - step_inc) : (sel_cur + step_inc);
    assign last_ax   = (r_ax == AX_W'(AXES - 1));

    assign elapsed_inc = (r_elapsed != '1) ? (r_elapsed + 1'b1) : r_elapsed;

    always_comb begin
        all_arrived = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            if (r_cur[i] != r_tgt[i]) all_arrived = 1'b0;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rep_pulse[k] = '0;
            for (int i = 0; i < AXES; i++) begin
                if (i == k) rep_pulse[k] = OUT_PULSE_BITS'(r_cur[i]);
            end
        end
    end

    // shared serial divider
    always_comb begin
        div_req.start = (r_state == S_MAP_START) || (r_state == S_STEP_START);
        if (r_state == S_STEP_START) begin
            div_req.dividend = DIVIDEND_BITS'(sel_dist);
            div_req.divisor  = DIVISOR_BITS'(r_d);
        end else begin
            div_req.dividend = map_mag[DIVIDEND_BITS-1:0];
            div_req.divisor  = DIVISOR_BITS'(MAP_SPAN_DEG);
        end
    end

    svi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign rsp_free      = !r_rsp_valid || o_rsp.ready;
    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LIMIT_SETS; i++) begin
                r_cfg_min[i] <= MIN_PULSE_RST;
                r_cfg_max[i] <= MAX_PULSE_RST;
            end
            r_interval <= INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COXA_MIN:  r_cfg_min[0] <= i_cfg_wdata[CFG_PULSE_BITS-1:0];
                CFG_COXA_MAX:  r_cfg_max[0] <= i_cfg_wdata[CFG_PULSE_BITS-1:0];
                CFG_FEMUR_MIN: r_cfg_min[1] <= i_cfg_wdata[CFG_PULSE_BITS-1:0];
                CFG_FEMUR_MAX: r_cfg_max[1] <= i_cfg_wdata[CFG_PULSE_BITS-1:0];
                CFG_TIBIA_MIN: r_cfg_min[2] <= i_cfg_wdata[CFG_PULSE_BITS-1:0];
                CFG_TIBIA_MAX: r_cfg_max[2] <= i_cfg_wdata[CFG_PULSE_BITS-1:0];
                CFG_INTERVAL:  r_interval   <= i_cfg_wdata[INTERVAL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_type      <= REQ_SET;
            r_ax        <= '0;
            r_d         <= '0;
            r_neg       <= 1'b0;
            r_moved     <= 1'b0;
            r_elapsed   <= '0;
            r_rsp_valid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
            end
            for (int i = 0; i < LIMIT_SETS; i++) begin
                r_ang[i] <= '0;
            end
        end else begin
            if ((r_state == S_DONE) && rsp_free) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_type   <= i_req.payload.req_type;
                        r_ang[0] <= i_req.payload.hip_angle;
                        r_ang[1] <= i_req.payload.upper_angle;
                        r_ang[2] <= i_req.payload.lower_angle;
                        r_ax     <= '0;
                        r_d      <= '0;
                        r_moved  <= 1'b0;
                        case (i_req.payload.req_type)
                            REQ_SET, REQ_SNAP: r_state <= S_MAP_START;
                            REQ_TICK: begin
                                if (elapsed_inc > r_interval) begin
                                    r_elapsed <= '0;
                                    r_state   <= S_DMIN;
                                end else begin
                                    r_elapsed <= elapsed_inc;
                                    r_state   <= S_DONE;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_MAP_START: begin
                    r_neg   <= map_prod[MAP_PROD_BITS-1];
                    r_state <= S_MAP_DIV;
                end
                S_MAP_DIV: begin
                    if (div_rsp.done) begin
                        r_tgt[r_ax] <= map_pulse;
                        if (r_type == REQ_SNAP) r_cur[r_ax] <= map_pulse;
                        if (last_ax) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= S_MAP_START;
                        end
                    end
                end
                S_DMIN: begin
                    r_d <= dmin_next;
                    if (last_ax) begin
                        r_ax <= '0;
                        if (dmin_next == '0) r_state <= S_DONE;
                        else                 r_state <= S_STEP_START;
                    end else begin
                        r_ax <= r_ax + 1'b1;
                    end
                end
                S_STEP_START: begin
                    r_state <= S_STEP_DIV;
                end
                S_STEP_DIV: begin
                    if (div_rsp.done) begin
                        r_cur[r_ax] <= step_next;
                        if (last_ax) begin
                            r_moved <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= S_STEP_START;
                        end
                    end
                end
                S_DONE: begin
                    if (rsp_free) begin
                        r_rsp.hip_pulse   <= rep_pulse[0];
                        r_rsp.upper_pulse <= rep_pulse[1];
                        r_rsp.lower_pulse <= rep_pulse[2];
                        r_rsp.moved       <= r_moved;
                        r_rsp.arrived     <= all_arrived;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/servo_sync_step_interpolator_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for servo_sync_step_interpolator_core: sends request transactions, predicts every
// response with a behavioral model of the three-axis interpolator and checks it field by field.
// Depends on svi_pkg, svi_req_if, svi_rsp_if and the core RTL.
module servo_sync_step_interpolator_core_tb;
    import svi_pkg::*;

    localparam logic [REQ_TYPE_BITS-1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 5000;
    localparam int SAT_TICKS     = 40;
    localparam int SEGMENT_ITEMS = 150;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata;

    svi_req_if req_if();
    svi_rsp_if rsp_if();

    servo_sync_step_interpolator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // behavioral copy of the axis state and limit registers
    logic [CFG_PULSE_BITS-1:0] lim_min [LIMIT_SETS];
    logic [CFG_PULSE_BITS-1:0] lim_max [LIMIT_SETS];
    logic [INTERVAL_BITS-1:0]  step_interval;
    logic [PULSE_BITS-1:0]     tgt_pulse [AXES];
    logic [PULSE_BITS-1:0]     cur_pulse [AXES];
    logic [INTERVAL_BITS-1:0]  ms_count;

    t_rsp pending_pulse_reports[$];
    int   src_idle_pct;
    int   snk_idle_pct;
    int   fail_cnt;
    int   sent_cnt;
    int   checked_cnt;
    int   moved_cnt;
    int   arrived_cnt;
    int   stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [PULSE_BITS-1:0] angle_to_pulse(int axis,
                                                             logic [ANGLE_BITS-1:0] ang);
        int     set_idx;
        longint lo;
        longint hi;
        longint a;
        longint v;
        set_idx = (axis < LIMIT_SETS) ? axis : LIMIT_SETS - 1;
        lo = longint'(lim_min[set_idx]);
        hi = longint'(lim_max[set_idx]);
        a  = longint'(ang);
        v  = (a - ANGLE_OFFSET) * (hi - lo) / MAP_SPAN_DEG + lo;
        if (v < lo) begin
            v = lo;
        end else if (v > hi) begin
            v = hi;
        end
        return v[PULSE_BITS-1:0];
    endfunction

    function automatic logic [PULSE_BITS-1:0] axis_gap(int i);
        return (cur_pulse[i] > tgt_pulse[i]) ? cur_pulse[i] - tgt_pulse[i]
                                             : tgt_pulse[i] - cur_pulse[i];
    endfunction

    function automatic t_rsp advance_servo_model(t_req r);
        t_rsp                  rsp;
        logic                  stepped;
        logic                  at_target;
        logic [PULSE_BITS-1:0] d;
        logic [PULSE_BITS-1:0] gap;
        logic [PULSE_BITS-1:0] inc;
        logic [ANGLE_BITS-1:0] ang [3];
        stepped = 1'b0;
        ang[0]  = r.hip_angle;
        ang[1]  = r.upper_angle;
        ang[2]  = r.lower_angle;
        case (r.req_type)
            REQ_SET, REQ_SNAP: begin
                for (int i = 0; i < AXES; i++) begin
                    tgt_pulse[i] = angle_to_pulse(i, ang[(i < 3) ? i : 2]);
                    if (r.req_type == REQ_SNAP) cur_pulse[i] = tgt_pulse[i];
                end
            end
            REQ_TICK: begin
                if (ms_count != '1) ms_count++;
                if (ms_count > step_interval) begin
                    // smallest nonzero distance sets the pace, others move in proportion
                    d = '0;
                    for (int i = 0; i < AXES; i++) begin
                        gap = axis_gap(i);
                        if (gap != 0 && (d == 0 || gap < d)) d = gap;
                    end
                    if (d != 0) begin
                        stepped = 1'b1;
                        for (int i = 0; i < AXES; i++) begin
                            gap = axis_gap(i);
                            inc = gap / d;
                            if (cur_pulse[i] > tgt_pulse[i]) cur_pulse[i] -= inc;
                            else cur_pulse[i] += inc;
                        end
                    end
                    ms_count = '0;
                end
            end
            default: ;
        endcase
        at_target = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            if (cur_pulse[i] != tgt_pulse[i]) at_target = 1'b0;
        end
        rsp.hip_pulse   = cur_pulse[0];
        rsp.upper_pulse = (AXES > 1) ? cur_pulse[1 % AXES] : '0;
        rsp.lower_pulse = (AXES > 2) ? cur_pulse[2 % AXES] : '0;
        rsp.moved       = stepped;
        rsp.arrived     = at_target;
        return rsp;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] rand_angle();
        return ($urandom_range(0, 4) == 0) ? ANGLE_BITS'($urandom_range(0, 255))
                                           : ANGLE_BITS'($urandom_range(0, 180));
    endfunction

    function automatic void check_field(string name, logic [15:0] expv, logic [15:0] gotv);
        if (gotv !== expv) begin
            $error("%s: expected %0d, actual %0d", name, expv, gotv);
            fail_cnt++;
        end
    endfunction

    task automatic send_req(input t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pending_pulse_reports.push_back(advance_servo_model(r));
        sent_cnt++;
    endtask

    task automatic send_kind(input logic [REQ_TYPE_BITS-1:0] kind,
                             input logic [ANGLE_BITS-1:0] hip,
                             input logic [ANGLE_BITS-1:0] upper,
                             input logic [ANGLE_BITS-1:0] lower);
        t_req r;
        r.req_type    = kind;
        r.hip_angle   = hip;
        r.upper_angle = upper;
        r.lower_angle = lower;
        send_req(r);
    endtask

    // sender holds off until every outstanding response has been checked
    task automatic drain_reports;
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_pulse_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_COXA_MIN:  lim_min[0] = data[CFG_PULSE_BITS-1:0];
            CFG_COXA_MAX:  lim_max[0] = data[CFG_PULSE_BITS-1:0];
            CFG_FEMUR_MIN: lim_min[1] = data[CFG_PULSE_BITS-1:0];
            CFG_FEMUR_MAX: lim_max[1] = data[CFG_PULSE_BITS-1:0];
            CFG_TIBIA_MIN: lim_min[2] = data[CFG_PULSE_BITS-1:0];
            CFG_TIBIA_MAX: lim_max[2] = data[CFG_PULSE_BITS-1:0];
            CFG_INTERVAL:  step_interval = data[INTERVAL_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_limits(input logic [CFG_PULSE_BITS-1:0] h_min,
                                input logic [CFG_PULSE_BITS-1:0] h_max,
                                input logic [CFG_PULSE_BITS-1:0] u_min,
                                input logic [CFG_PULSE_BITS-1:0] u_max,
                                input logic [CFG_PULSE_BITS-1:0] l_min,
                                input logic [CFG_PULSE_BITS-1:0] l_max,
                                input logic [INTERVAL_BITS-1:0]  ivl);
        write_reg(CFG_COXA_MIN, CFG_DATA_BITS'(h_min));
        write_reg(CFG_COXA_MAX, CFG_DATA_BITS'(h_max));
        write_reg(CFG_FEMUR_MIN, CFG_DATA_BITS'(u_min));
        write_reg(CFG_FEMUR_MAX, CFG_DATA_BITS'(u_max));
        write_reg(CFG_TIBIA_MIN, CFG_DATA_BITS'(l_min));
        write_reg(CFG_TIBIA_MAX, CFG_DATA_BITS'(l_max));
        write_reg(CFG_INTERVAL, CFG_DATA_BITS'(ivl));
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_state;
        send_kind(REQ_UNUSED, 8'd255, 8'd255, 8'd255);
        send_kind(REQ_SNAP, 8'd90, 8'd90, 8'd90);
        send_kind(REQ_SET, 8'd0, 8'd180, 8'd45);
        send_kind(REQ_SET, 8'd255, 8'd0, 8'd135);
        drain_reports;
    endtask

    task automatic test_tick_interval;
        apply_limits(12'd150, 12'd600, 12'd150, 12'd600, 12'd150, 12'd600, 16'd2);
        repeat (4) send_kind(REQ_TICK, 8'd0, 8'd0, 8'd0);
        drain_reports;
    endtask

    // hip is the pacing axis; the others cover 45 and 90 units per step, then all arrive
    task automatic test_step_ratios;
        apply_limits(12'd150, 12'd600, 12'd150, 12'd600, 12'd150, 12'd600, 16'd0);
        send_kind(REQ_SNAP, 8'd45, 8'd45, 8'd45);
        send_kind(REQ_SET, 8'd46, 8'd90, 8'd135);
        repeat (6) send_kind(REQ_TICK, 8'd128, 8'd64, 8'd32);
        drain_reports;
    endtask

    task automatic test_inverted_limits;
        apply_limits(12'd4095, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 16'd0);
        send_kind(REQ_SET, 8'd135, 8'd45, 8'd90);
        send_kind(REQ_SNAP, 8'd0, 8'd255, 8'd128);
        send_kind(REQ_TICK, 8'd1, 8'd2, 8'd4);
        send_kind(REQ_SET, 8'd180, 8'd180, 8'd0);
        send_kind(REQ_TICK, 8'd8, 8'd16, 8'd32);
        drain_reports;
    endtask

    // interval at full scale: the ms count can never exceed it, so no step runs
    task automatic test_count_saturation;
        apply_limits(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 16'hFFFF);
        send_kind(REQ_SNAP, 8'd45, 8'd45, 8'd45);
        send_kind(REQ_SET, 8'd135, 8'd90, 8'd100);
        repeat (SAT_TICKS) send_kind(REQ_TICK, rand_angle(), rand_angle(), rand_angle());
        drain_reports;
        apply_limits(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 16'd100);
        repeat (3) send_kind(REQ_TICK, 8'd0, 8'd0, 8'd0);
        drain_reports;
    endtask

    task automatic run_random_segment(input int style, input int n_items);
        logic [CFG_PULSE_BITS-1:0] mn [3];
        logic [CFG_PULSE_BITS-1:0] mx [3];
        logic [INTERVAL_BITS-1:0]  ivl;
        t_req                      r;
        int                        pick;
        for (int a = 0; a < 3; a++) begin
            pick = (style < 2) ? style : $urandom_range(0, 5);
            case (pick)
                0: begin
                    mn[a] = '0;
                    mx[a] = '1;
                end
                1: begin
                    mx[a] = CFG_PULSE_BITS'($urandom_range(0, 2000));
                    mn[a] = mx[a] + CFG_PULSE_BITS'($urandom_range(1, 2095));
                end
                default: begin
                    mn[a] = CFG_PULSE_BITS'($urandom_range(0, 3900));
                    mx[a] = mn[a] + CFG_PULSE_BITS'($urandom_range(0, 195));
                end
            endcase
        end
        case ($urandom_range(0, 5))
            0:       ivl = 16'd20;
            1:       ivl = INTERVAL_BITS'($urandom_range(4, 12));
            default: ivl = INTERVAL_BITS'($urandom_range(0, 3));
        endcase
        drain_reports;
        apply_limits(mn[0], mx[0], mn[1], mx[1], mn[2], mx[2], ivl);
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 99) == 0) drain_reports;
            pick          = $urandom_range(0, 99);
            r.hip_angle   = rand_angle();
            r.upper_angle = rand_angle();
            r.lower_angle = rand_angle();
            if (pick < 10) r.req_type = REQ_SET;
            else if (pick < 14) r.req_type = REQ_SNAP;
            else if (pick < 17) r.req_type = REQ_UNUSED;
            else r.req_type = REQ_TICK;
            send_req(r);
        end
    endtask

    task automatic test_random_traffic;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 23;
                    snk_idle_pct = 77;
                end
                1: begin
                    src_idle_pct = 77;
                    snk_idle_pct = 23;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                run_random_segment((seg == 0) ? phase : 2, SEGMENT_ITEMS);
            end
        end
        drain_reports;
    endtask

    // response side: random backpressure, checking and stall tracking
    initial begin
        t_rsp got;
        t_rsp want;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                got = rsp_if.payload;
                if (pending_pulse_reports.size() == 0) begin
                    $error("response transaction with no request outstanding: %h", got);
                    fail_cnt++;
                end else begin
                    want = pending_pulse_reports.pop_front();
                    check_field("hip_pulse", 16'(want.hip_pulse), 16'(got.hip_pulse));
                    check_field("upper_pulse", 16'(want.upper_pulse), 16'(got.upper_pulse));
                    check_field("lower_pulse", 16'(want.lower_pulse), 16'(got.lower_pulse));
                    check_field("moved", 16'(want.moved), 16'(got.moved));
                    check_field("arrived", 16'(want.arrived), 16'(got.arrived));
                    checked_cnt++;
                    if (want.moved) moved_cnt++;
                    if (want.arrived) arrived_cnt++;
                end
            end
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin : watchdog
        do @(posedge i_clk); while (stall_cycles < STALL_LIMIT);
        $display("FAIL servo_sync_step_interpolator_core");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= '0;
        i_cfg_wdata    <= '0;
        for (int i = 0; i < LIMIT_SETS; i++) begin
            lim_min[i] = MIN_PULSE_RST;
            lim_max[i] = MAX_PULSE_RST;
        end
        for (int i = 0; i < AXES; i++) begin
            tgt_pulse[i] = '0;
            cur_pulse[i] = '0;
        end
        step_interval = INTERVAL_RST;
        ms_count      = '0;
        src_idle_pct  = 23;
        snk_idle_pct  = 77;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state;
        test_tick_interval;
        test_step_ratios;
        test_inverted_limits;
        test_count_saturation;
        test_random_traffic;

        drain_reports;
        repeat (100) @(posedge i_clk);
        $display("Covered set/snap/tick/unused requests over default, full-scale, inverted and");
        $display("random limits, full-scale interval: %0d sent, %0d checked, %0d stepped,",
                 sent_cnt, checked_cnt, moved_cnt);
        $display("%0d arrived", arrived_cnt);
        if (fail_cnt == 0) begin
            $display("PASS servo_sync_step_interpolator_core");
        end else begin
            $display("FAIL servo_sync_step_interpolator_core");
        end
        $finish;
    end

endmodule
